// ===== hw/rtl/rbfs_pkg.sv =====
// Shared types, constants and helpers for the ring buffer frame finder.
`timescale 1ns / 1ps

package rbfs_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int PTR_W     = 8;
  localparam int MARK_MAX  = 4;
  localparam int POP_MAX   = 16;
  localparam int CNT_W     = $clog2(POP_MAX + 1);
  localparam int MARK_CAP  = (MARK_MAX < 4) ? MARK_MAX : 4;

  typedef enum logic [1:0] {
    MODE_PUSH     = 2'd0,
    MODE_POP      = 2'd1,
    MODE_SEARCH   = 2'd2,
    MODE_SET_TAIL = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_HEADER_BYTES   = 2'd0,
    CFG_HEADER_LENGTH  = 2'd1,
    CFG_TRAILER_BYTES  = 2'd2,
    CFG_TRAILER_LENGTH = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_WAIT,
    S_POP_EMIT,
    S_CHECK,
    S_READ_WAIT,
    S_COMPARE,
    S_DONE
  } state_t;

  // Pattern length clamped to 1..MARK_CAP.
  function automatic logic [2:0] eff_len(input logic [2:0] len);
    logic [2:0] r;
    r = len;
    if (r == 3'd0) r = 3'd1;
    if (r > 3'(MARK_CAP)) r = 3'(MARK_CAP);
    return r;
  endfunction

  // Byte k of a four byte pattern, first byte in bits 7..0.
  function automatic logic [7:0] pat_byte(input logic [31:0] pat, input logic [1:0] k);
    return pat[8*k +: 8];
  endfunction

endpackage

// ===== hw/rtl/rbfs_if.sv =====
// Valid/ready channel interfaces: input items, results and register writes.
`timescale 1ns / 1ps

interface rbfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic [4:0] pop_limit;
  logic [7:0] new_tail;

  modport source (output valid, mode, data_byte, pop_limit, new_tail, input ready);
  modport sink   (input valid, mode, data_byte, pop_limit, new_tail, output ready);
endinterface

interface rbfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       found;
  logic [7:0] frame_start;
  logic [7:0] frame_stop;
  logic       last;

  modport source (output valid, out_byte, byte_valid, found, frame_start, frame_stop, last,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, found, frame_start, frame_stop, last,
                  output ready);
endinterface

interface rbfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rbfs_ram.sv =====
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module rbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ring_buffer_frame_sync.sv =====
// Top level: byte ring buffer with header/trailer frame search.
`timescale 1ns / 1ps

// A 256-byte ring buffer with a frame finder. Each input word carries a mode:
// push stores data_byte at the head (no fullness check, the head wraps and a
// full wrap reads as empty); pop returns min(stored, pop_limit, 16) bytes
// from the tail, one result word each, last set on the final one, or a single
// word with byte_valid low when nothing can be taken; search reports the
// first header that has a trailer after it, both wholly inside the stored
// bytes, as found / frame_start / exclusive frame_stop in one result word;
// set tail moves the tail to new_tail. Push and set tail leave the sequencer
// idle and may follow each other back to back. A pop reads each byte it
// returns through the one RAM read port (registered read), and waits on any
// stall on the result channel. A search runs one byte comparator over the
// store: each candidate position gets a bound check and then one registered
// read and compare per pattern byte, so the worst case grows with stored
// bytes times pattern length; the result word is then handed over. Items
// are not accepted while a pop or search is running; register writes are
// always taken. Store bytes reset to zero through a per-entry written flag,
// so no clearing pass is needed after reset.
module ring_buffer_frame_sync
  import rbfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  rbfs_in_if.sink    items,
  rbfs_out_if.source results,
  rbfs_cfg_if.sink   cfg
);

  // Configuration registers
  logic [31:0] header_bytes;
  logic [2:0]  header_length;
  logic [31:0] trailer_bytes;
  logic [2:0]  trailer_length;

  // Buffer pointers and per-entry written flags
  logic [PTR_W-1:0]     wp;
  logic [PTR_W-1:0]     rp;
  logic [BUF_DEPTH-1:0] written;
  logic [PTR_W-1:0]     count;

  // Sequencer state
  state_t           state, state_next;
  logic [CNT_W-1:0] pop_cnt;
  logic [PTR_W-1:0] pos;        // window offset from tail
  logic [1:0]       k;          // byte within the pattern
  logic             phase_trl;  // 0: header scan, 1: trailer scan
  logic [PTR_W-1:0] hstart;
  logic             found_r;
  logic [PTR_W-1:0] fstart;
  logic [PTR_W-1:0] fstop;

  // RAM port
  logic             ram_we;
  logic [PTR_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  logic             rd_written;
  logic [7:0]       rd_byte;

  // Output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_bvalid;
  logic       out_found;
  logic [7:0] out_start;
  logic [7:0] out_stop;
  logic       out_last;

  logic       in_fire;
  logic       out_free;
  logic       out_load;
  mode_t      in_mode;
  logic [2:0] lh, lt, cur_len;
  logic [7:0] cur_pat_byte;
  logic       byte_eq;
  logic       last_byte;
  logic       in_bounds;
  logic [PTR_W-1:0] take_cnt;
  logic [CNT_W-1:0] take;

  assign count    = wp - rp;
  assign in_mode  = mode_t'(items.mode);
  assign in_fire  = items.valid && items.ready;
  assign out_free = !out_valid || results.ready;

  assign lh      = eff_len(header_length);
  assign lt      = eff_len(trailer_length);
  assign cur_len = phase_trl ? lt : lh;
  assign cur_pat_byte = phase_trl ? pat_byte(trailer_bytes, k) : pat_byte(header_bytes, k);

  // Never-written entries read as zero
  assign rd_byte   = rd_written ? ram_rdata : 8'd0;
  assign byte_eq   = (rd_byte == cur_pat_byte);
  assign last_byte = (k == 2'(cur_len - 3'd1));
  assign in_bounds = ({1'b0, pos} + {6'b0, cur_len}) <= {1'b0, count};

  // take = min(count, pop_limit, POP_MAX)
  always_comb begin
    take_cnt = (count < {3'b0, items.pop_limit}) ? count : {3'b0, items.pop_limit};
    if (take_cnt > PTR_W'(POP_MAX)) begin
      take_cnt = PTR_W'(POP_MAX);
    end
    take = CNT_W'(take_cnt);
  end

  rbfs_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (items.data_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_mode)
            MODE_POP:    state_next = (take == '0) ? S_DONE : S_POP_WAIT;
            MODE_SEARCH: state_next = S_CHECK;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_POP_WAIT: state_next = S_POP_EMIT;
      S_POP_EMIT: begin
        if (out_free) begin
          state_next = (pop_cnt == CNT_W'(1)) ? S_IDLE : S_POP_WAIT;
        end
      end
      S_CHECK:     state_next = in_bounds ? S_READ_WAIT : S_DONE;
      S_READ_WAIT: state_next = S_COMPARE;
      S_COMPARE: begin
        if (!byte_eq) begin
          state_next = S_CHECK;
        end else if (last_byte) begin
          state_next = phase_trl ? S_DONE : S_CHECK;
        end else begin
          state_next = S_READ_WAIT;
        end
      end
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    items.ready = (state == S_IDLE);
    cfg.ready   = 1'b1;
    ram_we      = in_fire && (in_mode == MODE_PUSH);
    out_load    = ((state == S_POP_EMIT) || (state == S_DONE)) && out_free;
    unique case (state)
      S_CHECK, S_READ_WAIT, S_COMPARE: ram_raddr = rp + pos + {6'b0, k};
      default:                         ram_raddr = rp;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      wp             <= '0;
      rp             <= '0;
      written        <= '0;
      out_valid      <= 1'b0;
      header_bytes   <= '0;
      header_length  <= 3'd1;
      trailer_bytes  <= '0;
      trailer_length <= 3'd1;
    end else begin
      state <= state_next;

      if (cfg.valid && cfg.ready) begin
        unique case (cfg_index_t'(cfg.index))
          CFG_HEADER_BYTES:   header_bytes   <= cfg.data;
          CFG_HEADER_LENGTH:  header_length  <= cfg.data[2:0];
          CFG_TRAILER_BYTES:  trailer_bytes  <= cfg.data;
          CFG_TRAILER_LENGTH: trailer_length <= cfg.data[2:0];
          default: ;
        endcase
      end

      if (in_fire && (in_mode == MODE_PUSH)) begin
        written[wp] <= 1'b1;
        wp          <= wp + 1'b1;
      end
      if (in_fire && (in_mode == MODE_SET_TAIL)) begin
        rp <= items.new_tail;
      end
      if ((state == S_POP_EMIT) && out_free) begin
        rp <= rp + 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_written <= written[ram_raddr];

    if (in_fire && (in_mode == MODE_POP)) begin
      pop_cnt <= take;
      found_r <= 1'b0;
    end
    if ((state == S_POP_EMIT) && out_free) begin
      pop_cnt <= pop_cnt - 1'b1;
    end

    if (in_fire && (in_mode == MODE_SEARCH)) begin
      pos       <= '0;
      k         <= '0;
      phase_trl <= 1'b0;
      found_r   <= 1'b0;
    end

    if (state == S_COMPARE) begin
      if (!byte_eq) begin
        // slide the window one byte
        k   <= '0;
        pos <= pos + 1'b1;
      end else if (last_byte) begin
        k <= '0;
        if (phase_trl) begin
          found_r <= 1'b1;
          fstart  <= rp + hstart;
          fstop   <= rp + pos + {5'b0, lt};
        end else begin
          // header matched: trailer may start right after it
          hstart    <= pos;
          pos       <= pos + {5'b0, lh};
          phase_trl <= 1'b1;
        end
      end else begin
        k <= k + 1'b1;
      end
    end

    if (out_load) begin
      if (state == S_POP_EMIT) begin
        out_byte   <= rd_byte;
        out_bvalid <= 1'b1;
        out_found  <= 1'b0;
        out_start  <= '0;
        out_stop   <= '0;
        out_last   <= (pop_cnt == CNT_W'(1));
      end else begin
        out_byte   <= '0;
        out_bvalid <= 1'b0;
        out_found  <= found_r;
        out_start  <= found_r ? fstart : 8'd0;
        out_stop   <= found_r ? fstop : 8'd0;
        out_last   <= 1'b1;
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.out_byte    = out_byte;
  assign results.byte_valid  = out_bvalid;
  assign results.found       = out_found;
  assign results.frame_start = out_start;
  assign results.frame_stop  = out_stop;
  assign results.last        = out_last;

`ifndef SYNTHESIS
  // Pattern byte index stays inside the active pattern length.
  a_k_in_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPARE) |-> ({1'b0, k} < cur_len))
    else $error("pattern byte index beyond pattern length");

  // A pop never emits with its byte count exhausted.
  a_pop_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_EMIT) |-> (pop_cnt != '0))
    else $error("pop emit with zero remaining count");

  // A popped byte word never claims a frame.
  a_pop_no_found: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.byte_valid) |-> !results.found)
    else $error("popped byte marked as found frame");

  // Items are only taken with no pop or search in flight.
  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !items.ready)
    else $error("item accepted while sequencer busy");
`endif

endmodule
